// ----- rtl/sdic_pkg.sv -----
package sdic_pkg;

   localparam int ID_WIDTH         = 32;
   localparam int SIZE_WIDTH       = 16;
   localparam int TOTAL_WIDTH      = 7;
   localparam int MAX_DISTINCT_DEF = 64;
   localparam int COUNT_BITS_DEF   = 16;

   // Broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic insert;  // place a new ID in sorted order, cells above it move up
      logic bump;    // the ID is already held, the matching cell counts it
      logic drain;   // every cell takes its upper neighbor's entry
   } cell_ctrl_type;

endpackage

// ----- rtl/sorted_distinct_id_counter.sv -----
// Collecting: one ID is taken each cycle; the whole cell chain compares and inserts at once.
// After the last ID of a set is taken, the first result is offered on the next cycle and the
// chain shifts one entry toward the output per result taken, so a set that leaves N IDs in the
// table holds req_ready low for N result transactions.
// Reset (synchronous, active high) empties every cell and clears the count and both flags.
module sorted_distinct_id_counter #(
   parameter int MAX_DISTINCT = sdic_pkg::MAX_DISTINCT_DEF,
   parameter int COUNT_BITS   = sdic_pkg::COUNT_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [sdic_pkg::ID_WIDTH-1:0]      req_grain_id,
   input  logic                                      req_last_item,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [sdic_pkg::ID_WIDTH-1:0]      rsp_unique_id,
   output logic        [sdic_pkg::SIZE_WIDTH-1:0]    rsp_grain_size,
   output logic        [sdic_pkg::TOTAL_WIDTH-1:0]   rsp_distinct_total,
   output logic                                      rsp_final_result,
   output logic                                      rsp_table_overflow,
   output logic                                      rsp_size_saturated
);

   localparam int ENTRY_W = $clog2(MAX_DISTINCT + 1);
   localparam int SW      = sdic_pkg::SIZE_WIDTH;
   localparam int TW      = sdic_pkg::TOTAL_WIDTH;

   typedef enum logic [1:0] {
      ST_COLLECT = 2'b01,
      ST_DRAIN   = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [ENTRY_W-1:0]       entry_ff, entry_in;
   logic                     overflow_ff, overflow_in;
   logic                     saturate_ff, saturate_in;

   sdic_pkg::cell_ctrl_type  ctrl;
   logic                     accept, full, any_hit, any_sat, last_out;

   logic                                 cell_valid [MAX_DISTINCT];
   logic signed [sdic_pkg::ID_WIDTH-1:0] cell_id    [MAX_DISTINCT];
   logic        [COUNT_BITS-1:0]         cell_count [MAX_DISTINCT];
   logic        [MAX_DISTINCT-1:0]       above_vec, hit_vec, sat_vec;

   genvar g;
   generate
      for (g = 0; g < MAX_DISTINCT; g++) begin : g_cell
         logic                                 lv, rv, la;
         logic signed [sdic_pkg::ID_WIDTH-1:0] lid, rid;
         logic        [COUNT_BITS-1:0]         lc, rc;

         if (g == 0) begin : g_first
            assign lv  = 1'b0;
            assign lid = '0;
            assign lc  = '0;
            assign la  = 1'b0;
         end else begin : g_mid_left
            assign lv  = cell_valid[g-1];
            assign lid = cell_id[g-1];
            assign lc  = cell_count[g-1];
            assign la  = above_vec[g-1];
         end

         if (g == MAX_DISTINCT - 1) begin : g_last
            assign rv  = 1'b0;
            assign rid = '0;
            assign rc  = '0;
         end else begin : g_mid_right
            assign rv  = cell_valid[g+1];
            assign rid = cell_id[g+1];
            assign rc  = cell_count[g+1];
         end

         sdic_cell #(
            .COUNT_BITS(COUNT_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .grain_id   (req_grain_id),
            .left_valid (lv),
            .left_id    (lid),
            .left_count (lc),
            .left_above (la),
            .right_valid(rv),
            .right_id   (rid),
            .right_count(rc),
            .valid      (cell_valid[g]),
            .id         (cell_id[g]),
            .count      (cell_count[g]),
            .above      (above_vec[g]),
            .hit        (hit_vec[g]),
            .sat        (sat_vec[g])
         );
      end
   endgenerate

   assign req_ready = (state_ff == ST_COLLECT);
   assign accept    = req_valid && req_ready;
   assign full      = (entry_ff == ENTRY_W'(MAX_DISTINCT));
   assign any_hit   = |hit_vec;
   assign any_sat   = |sat_vec;

   assign rsp_valid = (state_ff == ST_DRAIN);
   assign last_out  = !cell_valid[1];

   assign ctrl.insert = accept && !any_hit && !full;
   assign ctrl.bump   = accept && any_hit;
   assign ctrl.drain  = rsp_valid && rsp_ready;

   always_comb begin
      state_in    = state_ff;
      entry_in    = entry_ff;
      overflow_in = overflow_ff;
      saturate_in = saturate_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (ctrl.insert) begin
               entry_in = entry_ff + 1'b1;
            end
            if (accept && !any_hit && full) begin
               overflow_in = 1'b1;
            end
            if (accept && any_sat) begin
               saturate_in = 1'b1;
            end
            if (accept && req_last_item) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The table empties itself by shifting; the totals clear with the final transaction.
            if (ctrl.drain && last_out) begin
               state_in    = ST_COLLECT;
               entry_in    = '0;
               overflow_in = 1'b0;
               saturate_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_COLLECT;
         entry_ff    <= '0;
         overflow_ff <= 1'b0;
         saturate_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         entry_ff    <= entry_in;
         overflow_ff <= overflow_in;
         saturate_ff <= saturate_in;
      end
   end

   assign rsp_unique_id      = cell_id[0];
   assign rsp_grain_size     = SW'(cell_count[0]);
   assign rsp_distinct_total = TW'(entry_ff);
   assign rsp_final_result   = last_out;
   assign rsp_table_overflow = overflow_ff;
   assign rsp_size_saturated = saturate_ff;

endmodule

// ----- rtl/sdic_cell.sv -----
module sdic_cell #(
   parameter int COUNT_BITS = sdic_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sdic_pkg::cell_ctrl_type              ctrl,
   input  logic signed [sdic_pkg::ID_WIDTH-1:0] grain_id,
   input  logic                                 left_valid,
   input  logic signed [sdic_pkg::ID_WIDTH-1:0] left_id,
   input  logic        [COUNT_BITS-1:0]         left_count,
   input  logic                                 left_above,
   input  logic                                 right_valid,
   input  logic signed [sdic_pkg::ID_WIDTH-1:0] right_id,
   input  logic        [COUNT_BITS-1:0]         right_count,
   output logic                                 valid,
   output logic signed [sdic_pkg::ID_WIDTH-1:0] id,
   output logic        [COUNT_BITS-1:0]         count,
   output logic                                 above,
   output logic                                 hit,
   output logic                                 sat
);

   logic                                 valid_ff, valid_in;
   logic signed [sdic_pkg::ID_WIDTH-1:0] id_ff, id_in;
   logic        [COUNT_BITS-1:0]         count_ff, count_in;

   // The cell sits at or above the insertion point when it is empty or holds a larger ID.
   assign above = !valid_ff || (id_ff > grain_id);
   assign hit   = valid_ff && (id_ff == grain_id);
   assign sat   = hit && (count_ff == {COUNT_BITS{1'b1}});

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      count_in = count_ff;
      if (ctrl.drain) begin
         valid_in = right_valid;
         id_in    = right_id;
         count_in = right_count;
      end else if (ctrl.insert && above) begin
         if (left_above) begin
            valid_in = left_valid;
            id_in    = left_id;
            count_in = left_count;
         end else begin
            valid_in = 1'b1;
            id_in    = grain_id;
            count_in = COUNT_BITS'(1);
         end
      end else if (ctrl.bump && hit && !sat) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff    <= id_in;
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;
   assign count = count_ff;

endmodule

// ----- bench/tb_sorted_distinct_id_counter.sv -----
module tb_sorted_distinct_id_counter;

   localparam int MAX_IDS = sdic_pkg::MAX_DISTINCT_DEF;
   localparam logic [sdic_pkg::SIZE_WIDTH-1:0] SIZE_MAX = '1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 470;

   typedef logic signed [sdic_pkg::ID_WIDTH-1:0] grain_id_type;

   typedef struct {
      grain_id_type                       unique_id;
      logic [sdic_pkg::SIZE_WIDTH-1:0]    grain_size;
      logic [sdic_pkg::TOTAL_WIDTH-1:0]   distinct_total;
      logic                               final_result;
      logic                               table_overflow;
      logic                               size_saturated;
   } grain_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   grain_id_type                        req_grain_id = '0;
   logic                                req_last_item = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   grain_id_type                        rsp_unique_id;
   logic [sdic_pkg::SIZE_WIDTH-1:0]     rsp_grain_size;
   logic [sdic_pkg::TOTAL_WIDTH-1:0]    rsp_distinct_total;
   logic                                rsp_final_result;
   logic                                rsp_table_overflow;
   logic                                rsp_size_saturated;

   // Predicted contents of the sorted table for the data set in progress.
   grain_id_type                        held_ids[MAX_IDS];
   logic [sdic_pkg::SIZE_WIDTH-1:0]     held_sizes[MAX_IDS];
   int                                  held_count = 0;
   bit                                  ids_dropped = 1'b0;
   bit                                  size_stuck = 1'b0;
   grain_result_type                    histogram_q[$];

   bit                            send_idle = 1'b1;
   bit                            take_idle = 1'b1;
   int                            fail_count = 0;
   int                            cycle_count = 0;
   int                            items_sent = 0;
   int                            sets_sent = 0;
   int                            overflow_sets = 0;
   int                            saturated_sets = 0;
   int                            results_checked = 0;

   sorted_distinct_id_counter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_grain_id       (req_grain_id),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_unique_id      (rsp_unique_id),
      .rsp_grain_size     (rsp_grain_size),
      .rsp_distinct_total (rsp_distinct_total),
      .rsp_final_result   (rsp_final_result),
      .rsp_table_overflow (rsp_table_overflow),
      .rsp_size_saturated (rsp_size_saturated)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Counts one ID into the predicted table; on the last ID of a set it queues the
   // whole histogram in ascending order and clears the table.
   function automatic void tally_grain(grain_id_type id, bit last);
      int pos;
      grain_result_type r;
      pos = 0;
      while (pos < held_count && held_ids[pos] < id)
         pos++;
      if (pos < held_count && held_ids[pos] == id) begin
         if (held_sizes[pos] == SIZE_MAX)
            size_stuck = 1'b1;
         else
            held_sizes[pos]++;
      end else if (held_count == MAX_IDS) begin
         ids_dropped = 1'b1;
      end else begin
         for (int k = held_count; k > pos; k--) begin
            held_ids[k]   = held_ids[k-1];
            held_sizes[k] = held_sizes[k-1];
         end
         held_ids[pos]   = id;
         held_sizes[pos] = sdic_pkg::SIZE_WIDTH'(1);
         held_count++;
      end
      if (last) begin
         for (int k = 0; k < held_count; k++) begin
            r.unique_id      = held_ids[k];
            r.grain_size     = held_sizes[k];
            r.distinct_total = sdic_pkg::TOTAL_WIDTH'(held_count);
            r.final_result   = (k == held_count - 1);
            r.table_overflow = ids_dropped;
            r.size_saturated = size_stuck;
            histogram_q.push_back(r);
         end
         sets_sent++;
         if (ids_dropped)
            overflow_sets++;
         if (size_stuck)
            saturated_sets++;
         held_count  = 0;
         ids_dropped = 1'b0;
         size_stuck  = 1'b0;
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // The payload changes only once the previous transaction has been accepted.
   task automatic send_grain(grain_id_type id, bit last);
      int gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_grain_id  <= id;
      req_last_item <= last;
      do @(posedge clock); while (!req_ready);
      tally_grain(id, last);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (histogram_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic grain_id_type pick_grain_id();
      grain_id_type id;
      case ($urandom_range(0, 3))
         0: id = $urandom;
         1: id = grain_id_type'($urandom_range(0, 40)) - 20;
         2: case ($urandom_range(0, 3))
               0: id = 32'sh8000_0000;
               1: id = 32'sh7FFF_FFFF;
               2: id = '0;
               default: id = '1;
            endcase
         default: id = {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 255))};
      endcase
      return id;
   endfunction

   // Result side: a random stall before each transaction while take_idle is set, then the check
   // against the oldest queued expectation.
   initial begin
      int stall;
      grain_result_type want;
      while (reset)
         @(posedge clock);
      forever begin
         stall = take_idle ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (histogram_q.size() == 0) begin
            $error("unexpected result: unique_id %0d, grain_size %0d",
                   rsp_unique_id, rsp_grain_size);
            fail_count++;
         end else begin
            want = histogram_q.pop_front();
            check_field("unique_id", want.unique_id, rsp_unique_id);
            check_field("grain_size", want.grain_size, rsp_grain_size);
            check_field("distinct_total", want.distinct_total, rsp_distinct_total);
            check_field("final_result", want.final_result, rsp_final_result);
            check_field("table_overflow", want.table_overflow, rsp_table_overflow);
            check_field("size_saturated", want.size_saturated, rsp_size_saturated);
            results_checked++;
         end
      end
   end

   task automatic test_id_extremes();
      send_idle = 1'b1;
      take_idle = 1'b1;
      send_grain(32'sh7FFF_FFFF, 1'b0);
      send_grain(32'sh8000_0000, 1'b0);
      send_grain(0, 1'b0);
      send_grain(-1, 1'b0);
      send_grain(1, 1'b0);
      send_grain(32'sh8000_0000, 1'b0);
      send_grain(32'sh7FFF_FFFF, 1'b1);
      // Sets of a single item, with alternating bit patterns.
      send_grain(32'sh5555_5555, 1'b1);
      send_grain(32'shAAAA_AAAA, 1'b1);
   endtask

   task automatic test_repeats();
      send_idle = 1'b0;
      take_idle = 1'b1;
      repeat (5) send_grain(-9, 1'b0);
      send_grain(-9, 1'b1);
      // Descending arrival forces every new ID in at the front of the table.
      for (int i = 5; i >= 1; i--)
         send_grain(i, 1'b0);
      send_grain(3, 1'b1);
   endtask

   task automatic test_table_overflow();
      send_idle = 1'b1;
      take_idle = 1'b0;
      for (int i = MAX_IDS - 1; i >= 0; i--)
         send_grain(grain_id_type'(i * 977 - 31000), 1'b0);
      send_grain(-31000, 1'b0);
      send_grain(12345678, 1'b0);
      send_grain(-31000 + 977, 1'b0);
      // The last ID itself is dropped into the full table.
      send_grain(32'sh7FFF_FFFF, 1'b1);
      wait_for_results();
      // A table filled exactly by the last ID: no overflow.
      take_idle = 1'b1;
      for (int i = 0; i < MAX_IDS - 1; i++)
         send_grain(grain_id_type'(i * 3 - 100), 1'b0);
      send_grain(32'sh8000_0000, 1'b1);
   endtask

   task automatic test_size_saturation();
      send_idle = 1'b0;
      take_idle = 1'b0;
      // One short of saturation: the count reaches its maximum without the flag.
      repeat (int'(SIZE_MAX)) send_grain(-7, 1'b0);
      send_grain(8, 1'b1);
      send_grain(42, 1'b0);
      repeat (int'(SIZE_MAX)) send_grain(-7, 1'b0);
      send_grain(-7, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_sets();
      int items_left;
      int set_len;
      int pool_size;
      bit wide;
      grain_id_type pool[16];
      items_left = RANDOM_ITEMS;
      while (items_left > 0) begin
         send_idle = ($urandom_range(0, 3) != 0);
         take_idle = ($urandom_range(0, 3) != 0);
         wide = ($urandom_range(0, 9) == 0);
         set_len = wide ? $urandom_range(MAX_IDS + 1, MAX_IDS + 16) : $urandom_range(1, 24);
         pool_size = $urandom_range(1, 16);
         for (int i = 0; i < pool_size; i++)
            pool[i] = pick_grain_id();
         for (int i = 0; i < set_len; i++)
            send_grain(wide ? grain_id_type'($urandom) : pool[$urandom_range(0, pool_size - 1)],
                       i == set_len - 1);
         items_left -= set_len;
         if ($urandom_range(0, 4) == 0)
            wait_for_results();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_id_extremes();
      test_repeats();
      wait_for_results();
      test_table_overflow();
      test_size_saturation();
      test_random_sets();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (histogram_q.size() != 0) begin
         $error("%0d expected results never arrived", histogram_q.size());
         fail_count++;
      end
      $display("Run covered %0d IDs in %0d data sets and checked %0d results.",
               items_sent, sets_sent, results_checked);
      $display("%0d sets overflowed the table and %0d saturated a count.",
               overflow_sets, saturated_sets);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sorted_distinct_id_counter.f -----
rtl/sdic_pkg.sv
rtl/sdic_cell.sv
rtl/sorted_distinct_id_counter.sv
bench/tb_sorted_distinct_id_counter.sv
